FILE: src/lrupr_pkg.sv
// Package for the LRU page replacement block: widths, sizes and the
// control struct broadcast to the recency stack cells. No dependencies.
package lrupr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int CFG_W      = 5;
  localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int TOTAL_W    = 32;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = CFG_W'(16);

  typedef struct packed {
    logic accept;
    logic hit;
    logic full;
  } cell_ctrl_t;

endpackage

FILE: src/lrupr_in_if.sv
// Request channel of the LRU page replacement block: one page reference per beat.
// Depends on lrupr_pkg.
interface lrupr_in_if;
  logic                           valid;
  logic                           ready;
  logic [lrupr_pkg::PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

FILE: src/lrupr_out_if.sv
// Result channel of the LRU page replacement block: one result per beat.
// Depends on lrupr_pkg.
interface lrupr_out_if;
  logic                            valid;
  logic                            ready;
  logic                            fault;
  logic                            evicted_valid;
  logic [lrupr_pkg::PAGE_BITS-1:0] evicted_page;
  logic [lrupr_pkg::TOTAL_W-1:0]   fault_total;

  modport source (output valid, output fault, output evicted_valid, output evicted_page,
                  output fault_total, input ready);
  modport sink (input valid, input fault, input evicted_valid, input evicted_page,
                input fault_total, output ready);
endinterface

FILE: src/lrupr_cell.sv
// One entry of the recency stack: holds a page and its valid bit, compares it
// to the reference and takes its neighbor's entry when the stack shifts. Depends on lrupr_pkg.
module lrupr_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  lrupr_pkg::cell_ctrl_t           ctrl,
  input  logic [lrupr_pkg::PAGE_BITS-1:0] key,
  input  logic [lrupr_pkg::PAGE_BITS-1:0] prev_page,
  input  logic                            prev_valid,
  input  logic                            hit_above,
  output logic [lrupr_pkg::PAGE_BITS-1:0] page,
  output logic                            valid,
  output logic                            hit_out
);

  logic match;
  logic shift;

  assign match   = valid && (page == key);
  assign hit_out = hit_above || match;

  always_comb begin
    if (ctrl.hit) begin
      shift = ctrl.accept && !hit_above;
    end else if (ctrl.full) begin
      shift = ctrl.accept && valid;
    end else begin
      shift = ctrl.accept && (valid || prev_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      page <= prev_page;
    end
  end

endmodule

FILE: src/lru_page_replacement.sv
// Top level of the LRU page replacement block: a chain of recency stack cells
// with the most recent page at the head.
// Depends on lrupr_pkg, lrupr_in_if, lrupr_out_if, lrupr_cell.
//
//   Channel  Direction  Carries
//   req      in         page_number
//   rsp      out        fault, evicted_valid, evicted_page, fault_total
//   cfg      in         cfg_we, cfg_wdata (frame_count)
//
// A reference is looked up and the stack updated in the cycle it is accepted,
// so one beat is taken every cycle while rsp is ready; the result is registered
// and shows in the next cycle. The rate is set by the cell chain's compare and shift.
// A result waiting in the output register stalls req only while rsp is not ready.
// Reset empties the stack, clears the fault count and sets frame_count to 16.
module lru_page_replacement (
  input  logic                          clk,
  input  logic                          rst,
  lrupr_in_if.sink                      req,
  lrupr_out_if.source                   rsp,
  input  logic                          cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]   cfg_wdata
);

  logic [lrupr_pkg::CFG_W-1:0]     frame_count;
  logic [lrupr_pkg::COUNT_W-1:0]   resident_count;
  logic [lrupr_pkg::TOTAL_W-1:0]   fault_counter;
  logic [lrupr_pkg::TOTAL_W-1:0]   fault_counter_next;
  logic [lrupr_pkg::CFG_W-1:0]     cap;
  logic [lrupr_pkg::COUNT_W-1:0]   count_m1;
  logic [lrupr_pkg::PAGE_BITS-1:0] cell_page [lrupr_pkg::MAX_FRAMES];
  logic                            cell_valid [lrupr_pkg::MAX_FRAMES];
  logic                            hit_chain [lrupr_pkg::MAX_FRAMES+1];
  lrupr_pkg::cell_ctrl_t           ctrl;
  logic                            accept;
  logic                            full;
  logic                            miss;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  always_comb begin
    if (frame_count == '0) begin
      cap = lrupr_pkg::CFG_W'(1);
    end else if (int'(frame_count) > lrupr_pkg::MAX_FRAMES) begin
      cap = lrupr_pkg::CFG_W'(lrupr_pkg::MAX_FRAMES);
    end else begin
      cap = frame_count;
    end
  end

  assign full     = int'(resident_count) >= int'(cap);
  assign miss     = !hit_chain[lrupr_pkg::MAX_FRAMES];
  assign count_m1 = resident_count - lrupr_pkg::COUNT_W'(1);

  assign ctrl.accept = accept;
  assign ctrl.hit    = hit_chain[lrupr_pkg::MAX_FRAMES];
  assign ctrl.full   = full;

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin : g_cell
    if (i == 0) begin : g_head
      lrupr_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .key        (req.page_number),
        .prev_page  (req.page_number),
        .prev_valid (1'b1),
        .hit_above  (hit_chain[i]),
        .page       (cell_page[i]),
        .valid      (cell_valid[i]),
        .hit_out    (hit_chain[i+1])
      );
    end else begin : g_body
      lrupr_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .key        (req.page_number),
        .prev_page  (cell_page[i-1]),
        .prev_valid (cell_valid[i-1]),
        .hit_above  (hit_chain[i]),
        .page       (cell_page[i]),
        .valid      (cell_valid[i]),
        .hit_out    (hit_chain[i+1])
      );
    end
  end

  always_comb begin
    fault_counter_next = fault_counter;
    if (miss && (fault_counter != '1)) begin
      fault_counter_next = fault_counter + lrupr_pkg::TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= lrupr_pkg::FRAME_COUNT_RESET;
    end else if (cfg_we) begin
      frame_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resident_count <= '0;
      fault_counter  <= '0;
    end else if (accept) begin
      fault_counter <= fault_counter_next;
      if (miss && !full) begin
        resident_count <= resident_count + lrupr_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.fault         <= miss;
      rsp.evicted_valid <= miss && full;
      rsp.evicted_page  <= (miss && full) ? cell_page[count_m1[lrupr_pkg::IDX_W-1:0]] : '0;
      rsp.fault_total   <= fault_counter_next;
    end
  end

endmodule

FILE: tb/lru_page_replacement_tb.sv
// Self-checking testbench for the LRU page replacement block: page references in,
// fault and eviction results out, checked against a recency-list predictor.
// Depends on lrupr_pkg, lrupr_in_if, lrupr_out_if and lru_page_replacement.
module lru_page_replacement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                            fault;
    logic                            evicted_valid;
    logic [lrupr_pkg::PAGE_BITS-1:0] evicted_page;
    logic [lrupr_pkg::TOTAL_W-1:0]   fault_total;
  } page_outcome_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata;

  lrupr_in_if  req_if ();
  lrupr_out_if rsp_if ();

  lru_page_replacement dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: resident pages ordered from most to least recently used.
  logic [lrupr_pkg::PAGE_BITS-1:0] recency_list[$];
  logic [lrupr_pkg::CFG_W-1:0]     frame_count_setting;
  logic [lrupr_pkg::TOTAL_W-1:0]   fault_count;
  page_outcome_t                   pending_outcomes[$];

  logic [lrupr_pkg::PAGE_BITS-1:0] working_set[20];
  int                              src_idle_pct;
  int                              snk_idle_pct;
  int                              rsp_hold_cycles;
  int                              mismatches;

  always #10ns clk = ~clk;

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_if.valid <= 1'b0;
    req_if.page_number <= '0;
    rsp_if.ready <= 1'b0;
  end

  initial begin
    #20ms;
    $display("lru_page_replacement: mismatch");
    $finish;
  end

  function automatic int active_frames();
    int cap;
    cap = frame_count_setting;
    if (cap < 1) cap = 1;
    if (cap > lrupr_pkg::MAX_FRAMES) cap = lrupr_pkg::MAX_FRAMES;
    return cap;
  endfunction

  function automatic page_outcome_t lookup_page(input logic [lrupr_pkg::PAGE_BITS-1:0] page);
    page_outcome_t o;
    int            pos;
    o = '0;
    pos = -1;
    foreach (recency_list[i]) if (pos < 0 && recency_list[i] == page) pos = i;
    if (pos >= 0) begin
      recency_list.delete(pos);
    end else begin
      o.fault = 1'b1;
      if (fault_count != '1) fault_count++;
      if (recency_list.size() >= active_frames()) begin
        o.evicted_valid = 1'b1;
        o.evicted_page = recency_list.pop_back();
      end
    end
    recency_list.push_front(page);
    o.fault_total = fault_count;
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    page_outcome_t want;
    if (rst) begin
      recency_list.delete();
      pending_outcomes.delete();
      frame_count_setting = lrupr_pkg::FRAME_COUNT_RESET;
      fault_count = '0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result beat with no expectation waiting");
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp_if.fault !== want.fault)
            report_mismatch($sformatf("fault expected %0b got %0b", want.fault, rsp_if.fault));
          if (rsp_if.evicted_valid !== want.evicted_valid)
            report_mismatch($sformatf("evicted_valid expected %0b got %0b",
                                      want.evicted_valid, rsp_if.evicted_valid));
          if (rsp_if.evicted_page !== want.evicted_page)
            report_mismatch($sformatf("evicted_page expected %h got %h",
                                      want.evicted_page, rsp_if.evicted_page));
          if (rsp_if.fault_total !== want.fault_total)
            report_mismatch($sformatf("fault_total expected %0d got %0d",
                                      want.fault_total, rsp_if.fault_total));
        end
      end
      if (cfg_we) frame_count_setting = cfg_wdata;
      if (req_if.valid && req_if.ready)
        pending_outcomes.insert(pending_outcomes.size(), lookup_page(req_if.page_number));
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_cycles--;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_page(input logic [lrupr_pkg::PAGE_BITS-1:0] page);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.page_number <= page;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame_count(input logic [lrupr_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [lrupr_pkg::PAGE_BITS-1:0] pick_page(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return working_set[$urandom_range(0, span)];
    if (r < 95) return lrupr_pkg::PAGE_BITS'($urandom);
    return r[0] ? '0 : '1;
  endfunction

  task automatic test_fill_and_evict();
    logic [lrupr_pkg::PAGE_BITS-1:0] pages[21] = '{
      16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 16'h00FF,
      16'hFF00, 16'h0F0F, 16'hF0F0, 16'h1234, 16'h4321, 16'h7FFF, 16'hFFFE,
      16'h3C3C, 16'hC3C3, 16'h0000, 16'hBEEF, 16'h5555, 16'hBEEF, 16'hFFFF};
    src_idle_pct = 12;
    snk_idle_pct = 86;
    foreach (pages[i]) send_page(pages[i]);
    wait_drained();
  endtask

  task automatic test_output_stall();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_frame_count(lrupr_pkg::CFG_W'(16));
    foreach (working_set[i]) working_set[i] = lrupr_pkg::PAGE_BITS'($urandom);
    rsp_hold_cycles = 60;
    repeat (24) send_page(pick_page(17));
    wait_drained();
  endtask

  task automatic test_random_phase(input int src_pct, input int snk_pct);
    logic [lrupr_pkg::CFG_W-1:0] settings[5];
    int                          cap;
    settings = '{lrupr_pkg::CFG_W'(0), lrupr_pkg::CFG_W'(31), lrupr_pkg::CFG_W'(1),
                 lrupr_pkg::CFG_W'(17), lrupr_pkg::CFG_W'($urandom_range(2, 15))};
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    foreach (working_set[i]) working_set[i] = lrupr_pkg::PAGE_BITS'($urandom);
    foreach (settings[s]) begin
      set_frame_count(settings[s]);
      cap = (settings[s] == 0) ? 1 :
            (settings[s] > lrupr_pkg::MAX_FRAMES) ? lrupr_pkg::MAX_FRAMES : settings[s];
      repeat (30) send_page(pick_page((cap + 2 > 19) ? 19 : cap + 2));
    end
    wait_drained();
  endtask

  initial begin
    mismatches = 0;
    rsp_hold_cycles = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_and_evict();
    test_random_phase(12, 86);
    test_random_phase(86, 12);
    test_random_phase(0, 0);
    test_output_stall();
    wait_drained();
    if (mismatches == 0) begin
      $display("lru_page_replacement: match");
    end else begin
      $display("lru_page_replacement: mismatch");
    end
    $finish;
  end

endmodule
